FILE: rtl/pfba_pkg.sv
// Shared types and constants of the page frame bitmap allocator.
`default_nettype none

package pfba_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam logic [5:0]  TOP_BIT   = 6'd63;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    OP_ALLOC_DOWN = 2'd0,
    OP_ALLOC_AT   = 2'd1,
    OP_FREE       = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic rd_en;
    logic eval_en;
    logic push_en;
  } pfba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_next;
    logic out_free;
  } pfba_sts_t;

endpackage

`default_nettype wire

FILE: rtl/pfba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/pfba_ctrl.sv
// Sequencing state machine of the page frame bitmap allocator.
`default_nettype none

module pfba_ctrl
  import pfba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire pfba_sts_t sts,
  output pfba_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval_en = 1'b1;
        if (sts.scan_next) begin
          cmd.rd_en = 1'b1;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.push_en = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // sweep runs once after reset only
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("clearing pass re-entered");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_READ))
    else $error("accepted request not followed by read");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("request taken outside idle");

endmodule

`default_nettype wire

FILE: rtl/pfba_datapath.sv
// Bitmap memory, cursor, free count and result registers of the allocator.
`default_nettype none

module pfba_datapath
  import pfba_pkg::*;
#(
  parameter int unsigned POOL_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pfba_cmd_t   cmd,
  output pfba_sts_t        sts,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_frame_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [15:0]      out_granted_frame,
  output logic             out_frame_available,
  output logic [16:0]      out_free_frames
);

  localparam int unsigned WW          = $clog2(POOL_WORDS);
  localparam logic [31:0] FRAME_TOTAL = 32'(POOL_WORDS) * 32'(WORD_BITS);
  localparam logic [16:0] COUNT_CAP   =
    (FRAME_TOTAL < 32'(COUNT_MAX)) ? FRAME_TOTAL[16:0] : COUNT_MAX;
  localparam logic [WW-1:0] TOP_WORD  = WW'(POOL_WORDS - 1);

  function automatic logic [3:0] hi8(input logic [7:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        r = {1'b1, 3'(i)};
      end
    end
    return r;
  endfunction

  op_t           op_r;
  logic [15:0]   frame_r;
  logic [WW-1:0] cw_r, cw_nxt;
  logic [5:0]    cb_r, cb_nxt;
  logic [16:0]   free_r, free_nxt;
  logic [WW-1:0] clr_addr_r;
  logic          res_status_r, res_status_nxt;
  logic [15:0]   res_granted_r, res_granted_nxt;
  logic          res_avail_r, res_avail_nxt;
  logic          out_valid_r;
  logic          out_status_r;
  logic [15:0]   out_granted_r;
  logic          out_avail_r;
  logic [16:0]   out_free_r;

  logic [WW-1:0] fw, cw_dec, rd_addr, wr_addr;
  logic [31:0]   frame_ext;
  logic          in_range;
  logic [63:0]   rdata, wr_data, ram_wdata, lim_mask, cand, fmask;
  logic          wr_upd, ram_we;
  logic [7:0]    group_any;
  logic [3:0]    grp, bit_sel;
  logic [5:0]    hit_bit;
  logic          found, frame_clear;
  logic [16:0]   cnt_dn, cnt_up;
  logic          scan_next;

  assign frame_ext = 32'(frame_r);
  assign fw        = frame_ext[WW+5:6];
  assign in_range  = frame_ext < FRAME_TOTAL;
  assign cw_dec    = cw_r - WW'(1);
  assign rd_addr   = cmd.eval_en ? cw_dec : ((op_r == OP_ALLOC_DOWN) ? cw_r : fw);
  assign wr_addr   = (op_r == OP_ALLOC_DOWN) ? cw_r : fw;

  // highest clear bit at or below the cursor bit
  assign lim_mask = {64{1'b1}} >> (TOP_BIT - cb_r);
  assign cand     = ~rdata & lim_mask;
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      group_any[g] = |cand[g*8 +: 8];
    end
  end
  assign grp     = hi8(group_any);
  assign bit_sel = hi8(cand[{grp[2:0], 3'b000} +: 8]);
  assign found   = grp[3];
  assign hit_bit = {grp[2:0], bit_sel[2:0]};

  assign fmask       = 64'd1 << frame_r[5:0];
  assign frame_clear = (rdata & fmask) == 64'd0;
  assign cnt_dn      = (free_r != 17'd0) ? free_r - 17'd1 : free_r;
  assign cnt_up      = (free_r < COUNT_CAP) ? free_r + 17'd1 : free_r;

  always_comb begin
    cw_nxt          = cw_r;
    cb_nxt          = cb_r;
    free_nxt        = free_r;
    wr_upd          = 1'b0;
    wr_data         = rdata;
    res_status_nxt  = 1'b1;
    res_granted_nxt = 16'd0;
    res_avail_nxt   = 1'b0;
    scan_next       = 1'b0;
    case (op_r)
      OP_ALLOC_DOWN: begin
        if (cw_r != WW'(0)) begin
          if (found) begin
            cb_nxt          = hit_bit;
            wr_upd          = 1'b1;
            wr_data         = rdata | (64'd1 << hit_bit);
            free_nxt        = cnt_dn;
            res_status_nxt  = 1'b0;
            res_granted_nxt = 16'({cw_r, hit_bit});
          end else begin
            cb_nxt    = TOP_BIT;
            cw_nxt    = cw_dec;
            scan_next = (cw_r != WW'(1));
          end
        end
      end
      OP_ALLOC_AT: begin
        if (in_range) begin
          res_avail_nxt = frame_clear;
          if (frame_clear) begin
            wr_upd          = 1'b1;
            wr_data         = rdata | fmask;
            free_nxt        = cnt_dn;
            res_status_nxt  = 1'b0;
            res_granted_nxt = frame_r;
          end
        end
      end
      OP_FREE: begin
        if (in_range) begin
          res_avail_nxt   = frame_clear;
          wr_upd          = 1'b1;
          wr_data         = rdata & ~fmask;
          free_nxt        = cnt_up;
          res_status_nxt  = 1'b0;
          res_granted_nxt = frame_r;
        end
      end
      OP_QUERY: begin
        if (in_range) begin
          res_avail_nxt   = frame_clear;
          res_status_nxt  = 1'b0;
          res_granted_nxt = frame_r;
        end
      end
      default: begin
        res_status_nxt = 1'b1;
      end
    endcase
  end

  assign sts.scan_next = scan_next;

  assign ram_we    = cmd.clr_en | (cmd.eval_en & wr_upd);
  assign ram_wdata = cmd.clr_en ? {64{1'b1}} : wr_data;

  pfba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (POOL_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.clr_en ? clr_addr_r : wr_addr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign sts.clr_last = clr_addr_r == TOP_WORD;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r        <= TOP_WORD;
      cb_r        <= TOP_BIT;
      free_r      <= 17'd0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_addr_r <= clr_addr_r + WW'(1);
      end
      if (cmd.eval_en) begin
        cw_r   <= cw_nxt;
        cb_r   <= cb_nxt;
        free_r <= free_nxt;
      end
      if (cmd.push_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= op_t'(in_operation);
      frame_r <= in_frame_number;
    end
    if (cmd.eval_en && !scan_next) begin
      res_status_r  <= res_status_nxt;
      res_granted_r <= res_granted_nxt;
      res_avail_r   <= res_avail_nxt;
    end
    if (cmd.push_en) begin
      out_status_r  <= res_status_r;
      out_granted_r <= res_granted_r;
      out_avail_r   <= res_avail_r;
      out_free_r    <= free_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_frame   = out_granted_r;
  assign out_frame_available = out_avail_r;
  assign out_free_frames     = out_free_r;

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_en |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while held");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= COUNT_CAP)
    else $error("free count above frame total");

  a_cursor_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (cw_r == WW'(0)) |-> (cb_r == TOP_BIT))
    else $error("exhausted cursor not at top bit");

endmodule

`default_nettype wire

FILE: rtl/page_frame_bitmap_allocator.sv
// Top level of the page frame bitmap allocator.
// One usage bit per page frame is kept in a single-port-read RAM of POOL_WORDS 64-bit words.
// After reset a clearing pass marks every frame used, with in_stall high. One request is handled
// at a time: allocate-at, free, query, and an allocate-downward that finds a clear bit in the
// cursor word, pass through accept, RAM read, evaluate and result. Each further word scanned by
// allocate-downward is read from the RAM's registered read port while in evaluate. The result
// register lets the next request be accepted while a result still waits on out_stall.
`default_nettype none

module page_frame_bitmap_allocator
  import pfba_pkg::*;
#(
  parameter int unsigned POOL_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_frame_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [15:0]      out_granted_frame,
  output logic             out_frame_available,
  output logic [16:0]      out_free_frames
);

  pfba_cmd_t cmd;
  pfba_sts_t sts;

  pfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfba_datapath #(
    .POOL_WORDS (POOL_WORDS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_operation),
    .in_frame_number     (in_frame_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_frame   (out_granted_frame),
    .out_frame_available (out_frame_available),
    .out_free_frames     (out_free_frames)
  );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the page frame bitmap allocator.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfba_pkg::*;

  localparam int unsigned POOL_WORDS  = 1024;
  localparam int unsigned FRAME_TOTAL = POOL_WORDS * WORD_BITS;
  localparam int unsigned COUNT_CAP   = (FRAME_TOTAL < COUNT_MAX) ? FRAME_TOTAL : COUNT_MAX;
  localparam logic        STATUS_OK   = 1'b0;
  localparam logic        STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic        status;
    logic [15:0] frame;
    logic        avail;
    logic [16:0] free_cnt;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_QUERY;
  logic [15:0] in_frame_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_status;
  logic [15:0] out_granted_frame;
  logic        out_frame_available;
  logic [16:0] out_free_frames;

  // Predicted allocator state
  logic [63:0] frame_used [POOL_WORDS];
  logic [16:0] free_count = '0;
  logic [9:0]  cursor_word = 10'(POOL_WORDS - 1);
  logic [5:0]  cursor_bit = TOP_BIT;

  alloc_result_t pending_results[$];
  int            mismatches = 0;
  bit            calm = 1'b0;

  page_frame_bitmap_allocator #(
    .POOL_WORDS(POOL_WORDS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_frame_number     (in_frame_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_frame   (out_granted_frame),
    .out_frame_available (out_frame_available),
    .out_free_frames     (out_free_frames)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Highest clear frame at or below the cursor, above word 0
  function automatic bit find_down(output int word_idx, output int bit_idx);
    int w;
    int b;
    int lim;
    lim = int'(cursor_bit);
    for (w = int'(cursor_word); w >= 1; w--) begin
      for (b = lim; b >= 0; b--) begin
        if (!frame_used[w][b]) begin
          word_idx = w;
          bit_idx = b;
          return 1'b1;
        end
      end
      lim = int'(TOP_BIT);
    end
    word_idx = 0;
    bit_idx = int'(TOP_BIT);
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_request(input op_t op, input logic [15:0] frame);
    alloc_result_t r;
    int w;
    int b;
    int unsigned wi;
    int unsigned bi;
    r = '{status: STATUS_FAIL, frame: '0, avail: 1'b0, free_cnt: '0};
    if (op == OP_ALLOC_DOWN) begin
      if (find_down(w, b)) begin
        cursor_word = 10'(w);
        cursor_bit = 6'(b);
        frame_used[w][b] = 1'b1;
        if (free_count != 0) free_count--;
        r.status = STATUS_OK;
        r.frame = 16'(w * int'(WORD_BITS) + b);
      end else begin
        cursor_word = '0;
        cursor_bit = TOP_BIT;
      end
    end else if (int'(frame) < int'(FRAME_TOTAL)) begin
      wi = frame / WORD_BITS;
      bi = frame % WORD_BITS;
      r.avail = !frame_used[wi][bi];
      case (op)
        OP_ALLOC_AT: begin
          if (r.avail) begin
            frame_used[wi][bi] = 1'b1;
            if (free_count != 0) free_count--;
            r.status = STATUS_OK;
            r.frame = frame;
          end
        end
        OP_FREE: begin
          frame_used[wi][bi] = 1'b0;
          if (free_count < COUNT_CAP) free_count++;
          r.status = STATUS_OK;
          r.frame = frame;
        end
        default: begin
          r.status = STATUS_OK;
          r.frame = frame;
        end
      endcase
    end
    r.free_cnt = free_count;
    return r;
  endfunction

  function automatic logic [15:0] near_cursor();
    int f;
    f = int'(cursor_word) * int'(WORD_BITS) + int'(cursor_bit) - int'($urandom_range(255, 0));
    if (f < int'(WORD_BITS)) f = int'(WORD_BITS) + int'($urandom_range(255, 0));
    return f[15:0];
  endfunction

  task automatic idle_gap();
    while (!calm && $urandom_range(99, 0) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic issue_request(input op_t op, input logic [15:0] frame);
    idle_gap();
    in_valid <= 1'b1;
    in_operation <= op;
    in_frame_number <= frame;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(predict_request(op, frame));
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99, 0) < 14);
  end

  function automatic void check_field(input string label, input logic [16:0] want,
                                      input logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, label, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got frame %0d",
                 $realtime, out_granted_frame);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 17'(want.status), 17'(out_status));
        check_field("granted_frame", 17'(want.frame), 17'(out_granted_frame));
        check_field("frame_available", 17'(want.avail), 17'(out_frame_available));
        check_field("free_frames", want.free_cnt, out_free_frames);
      end
    end
  end

  task automatic test_reset_state();
    issue_request(OP_QUERY, 16'd0);
    issue_request(OP_QUERY, 16'hFFFF);
    issue_request(OP_ALLOC_AT, 16'd12345);
    issue_request(OP_QUERY, 16'hAAAA);
  endtask

  task automatic test_free_and_query();
    issue_request(OP_FREE, 16'hFFFF);
    issue_request(OP_FREE, 16'hFFFF);
    issue_request(OP_QUERY, 16'hFFFF);
    issue_request(OP_FREE, 16'd0);
    issue_request(OP_ALLOC_AT, 16'd0);
    issue_request(OP_QUERY, 16'd0);
  endtask

  task automatic test_downward_scan();
    issue_request(OP_FREE, 16'd65534);
    issue_request(OP_FREE, 16'd65472);
    issue_request(OP_FREE, 16'd65471);
    issue_request(OP_FREE, 16'd65400);
    issue_request(OP_ALLOC_DOWN, 16'd0);
    issue_request(OP_ALLOC_DOWN, 16'hFFFF);
    issue_request(OP_ALLOC_DOWN, 16'h5555);
    issue_request(OP_ALLOC_DOWN, 16'hAAAA);
    // cursor must not climb back to the freed top frame
    issue_request(OP_FREE, 16'd65535);
    issue_request(OP_FREE, 16'd65300);
    issue_request(OP_ALLOC_DOWN, 16'($urandom));
    issue_request(OP_ALLOC_AT, 16'd65535);
  endtask

  task automatic test_random_traffic(input int count);
    int w;
    int b;
    int pick;
    op_t op;
    logic [15:0] frame;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 2);
      pick = $urandom_range(99, 0);
      frame = near_cursor();
      if (pick < 30) begin
        op = OP_FREE;
      end else if (pick < 55) begin
        op = find_down(w, b) ? OP_ALLOC_DOWN : OP_FREE;
        if (op == OP_ALLOC_DOWN) frame = 16'($urandom);
      end else if (pick < 70) begin
        op = OP_ALLOC_AT;
      end else if (pick < 80) begin
        op = OP_QUERY;
      end else begin
        op = op_t'($urandom_range(3, 0));
        frame = 16'($urandom);
        if (op == OP_ALLOC_DOWN && !find_down(w, b)) op = OP_QUERY;
      end
      issue_request(op, frame);
    end
    calm = 1'b0;
  endtask

  task automatic test_exhaustion();
    int w;
    int b;
    issue_request(OP_FREE, 16'd64);
    issue_request(OP_FREE, 16'd63);
    while (find_down(w, b)) issue_request(OP_ALLOC_DOWN, 16'($urandom));
    issue_request(OP_ALLOC_DOWN, 16'($urandom));
    issue_request(OP_FREE, 16'd100);
    issue_request(OP_ALLOC_DOWN, 16'd100);
    issue_request(OP_ALLOC_AT, 16'd63);
    issue_request(OP_ALLOC_AT, 16'd100);
  endtask

  task automatic test_count_saturation();
    int f;
    for (f = 0; f < 24 && free_count < COUNT_CAP; f++) issue_request(OP_FREE, f[15:0]);
    repeat (3) issue_request(OP_FREE, 16'($urandom));
    issue_request(OP_QUERY, 16'hFFFF);
    issue_request(OP_ALLOC_AT, 16'hFFFF);
    issue_request(OP_ALLOC_DOWN, 16'hFFFF);
    issue_request(OP_FREE, 16'hFFFF);
    issue_request(OP_FREE, 16'hFFFF);
  endtask

  initial begin
    foreach (frame_used[i]) frame_used[i] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_free_and_query();
    test_downward_scan();
    test_random_traffic(1180);
    test_exhaustion();
    test_count_saturation();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/pfba_pkg.sv
rtl/pfba_ram.sv
rtl/pfba_ctrl.sv
rtl/pfba_datapath.sv
rtl/page_frame_bitmap_allocator.sv
bench/tb_top.sv
